// File: rtl/plcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the microcode ROM of the parallel panel bus master.
// No dependencies.
package plcd_pkg;

    localparam int MAX_FILL = 16;
    localparam int CNT_W    = 5;
    localparam int PC_W     = 5;

    typedef logic [PC_W-1:0]  pc_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // command codes
    localparam logic [2:0] CMD_RESET     = 3'd0;
    localparam logic [2:0] CMD_WRITE     = 3'd1;
    localparam logic [2:0] CMD_FILL      = 3'd2;
    localparam logic [2:0] CMD_ARR_START = 3'd3;
    localparam logic [2:0] CMD_ARR_WORD  = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_RESET = 3'd1,
        KIND_INDEX = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_READ  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_REG,
        SRC_WORD_HI,
        SRC_WORD_LO,
        SRC_PANEL_HI,
        SRC_PANEL_LO
    } src_t;

    // condition used for release and last flags
    typedef enum logic [2:0] {
        C_NO,
        C_YES,
        C_CNT_ZERO,
        C_CNT_ONE,
        C_LASTW
    } cond_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ARRAY   = 2'd1,
        ST_ARRAY_BUSY = 2'd2
    } st_t;

    // microcode word
    typedef struct packed {
        kind_t kind;
        src_t  src;
        logic  sel;
        cond_t rel;
        cond_t last;
        logic  rval_en;
        st_t   status;
        logic  arr_set;
        logic  arr_clr;
        logic  cnt_dec;
        logic  jmp;
        pc_t   target;
    } ucw_t;

    // resolved controls for one beat
    typedef struct packed {
        kind_t kind;
        src_t  src;
        logic  sel;
        logic  rel;
        logic  last;
        logic  rval_en;
        st_t   status;
        logic  arr_set;
        logic  arr_clr;
    } beat_ctl_t;

    // program entry points
    localparam pc_t PC_RST  = 5'd0;   // 5 steps
    localparam pc_t PC_WR   = 5'd5;   // 4 steps
    localparam pc_t PC_FILL = 5'd9;   // 4 steps, loop on the last two
    localparam pc_t PC_LOOP = 5'd11;
    localparam pc_t PC_AST  = 5'd13;  // 2 steps
    localparam pc_t PC_AWD  = 5'd15;  // 2 steps
    localparam pc_t PC_RD   = 5'd17;  // 4 steps
    localparam pc_t PC_ERR1 = 5'd21;
    localparam pc_t PC_ERR2 = 5'd22;
    localparam pc_t PC_NONE = 5'd23;

    function automatic ucw_t uc(kind_t k, src_t s, logic sel, cond_t rel, cond_t last,
                                logic rv, st_t st, logic aset, logic aclr, logic dec,
                                logic jmp, pc_t tgt);
        ucw_t w;
        w.kind    = k;
        w.src     = s;
        w.sel     = sel;
        w.rel     = rel;
        w.last    = last;
        w.rval_en = rv;
        w.status  = st;
        w.arr_set = aset;
        w.arr_clr = aclr;
        w.cnt_dec = dec;
        w.jmp     = jmp;
        w.target  = tgt;
        return w;
    endfunction

    function automatic ucw_t ucode_rom(pc_t pc);
        ucw_t w;
        unique case (pc)
            // reset: pulse, four zero index writes
            5'd0:  w = uc(KIND_RESET, SRC_ZERO, 1'b1, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd1, 5'd2, 5'd3:
                   w = uc(KIND_INDEX, SRC_ZERO, 1'b0, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd4:  w = uc(KIND_INDEX, SRC_ZERO, 1'b0, C_YES, C_YES, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            // write word
            5'd5:  w = uc(KIND_INDEX, SRC_ZERO, 1'b0, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd6:  w = uc(KIND_INDEX, SRC_REG, 1'b0, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd7:  w = uc(KIND_WRITE, SRC_WORD_HI, 1'b1, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd8:  w = uc(KIND_WRITE, SRC_WORD_LO, 1'b1, C_YES, C_YES, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            // fill: empty fill ends after the index phase
            5'd9:  w = uc(KIND_INDEX, SRC_ZERO, 1'b0, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd10: w = uc(KIND_INDEX, SRC_REG, 1'b0, C_CNT_ZERO, C_CNT_ZERO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd11: w = uc(KIND_WRITE, SRC_WORD_HI, 1'b1, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd12: w = uc(KIND_WRITE, SRC_WORD_LO, 1'b1, C_CNT_ONE, C_CNT_ONE, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b1, 1'b1, PC_LOOP);
            // array start
            5'd13: w = uc(KIND_INDEX, SRC_ZERO, 1'b0, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd14: w = uc(KIND_INDEX, SRC_REG, 1'b0, C_NO, C_YES, 1'b0, ST_OK,
                          1'b1, 1'b0, 1'b0, 1'b0, PC_RST);
            // array word
            5'd15: w = uc(KIND_WRITE, SRC_WORD_HI, 1'b1, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd16: w = uc(KIND_WRITE, SRC_WORD_LO, 1'b1, C_LASTW, C_YES, 1'b0, ST_OK,
                          1'b0, 1'b1, 1'b0, 1'b0, PC_RST);
            // read
            5'd17: w = uc(KIND_INDEX, SRC_ZERO, 1'b0, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd18: w = uc(KIND_INDEX, SRC_REG, 1'b0, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd19: w = uc(KIND_READ, SRC_PANEL_HI, 1'b1, C_NO, C_NO, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd20: w = uc(KIND_READ, SRC_PANEL_LO, 1'b1, C_YES, C_YES, 1'b1, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            // single-beat error and no-op results
            5'd21: w = uc(KIND_NONE, SRC_ZERO, 1'b1, C_NO, C_YES, 1'b0, ST_NO_ARRAY,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            5'd22: w = uc(KIND_NONE, SRC_ZERO, 1'b1, C_NO, C_YES, 1'b0, ST_ARRAY_BUSY,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
            default:
                   w = uc(KIND_NONE, SRC_ZERO, 1'b1, C_NO, C_YES, 1'b0, ST_OK,
                          1'b0, 1'b0, 1'b0, 1'b0, PC_RST);
        endcase
        return w;
    endfunction

endpackage

// File: rtl/plcd_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: entry decode, step counter, fill repeat counter.
// Depends on plcd_pkg (ROM and control types).
module plcd_seq
    import plcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] command,
    input  logic       array_open,
    input  logic [4:0] fill_count,
    input  logic       last_word,
    input  logic       step,
    output logic       busy,
    output beat_ctl_t  ctl
);

    logic busy_reg, busy_next;
    pc_t  pc_reg, pc_next;
    cnt_t cnt_reg, cnt_next;
    logic lastw_reg, lastw_next;
    pc_t  entry_pc;
    ucw_t ucw;
    logic cnt_zero, cnt_one;

    function automatic logic cond_eval(cond_t c, logic cz, logic c1, logic lw);
        logic r;
        unique case (c)
            C_NO:       r = 1'b0;
            C_YES:      r = 1'b1;
            C_CNT_ZERO: r = cz;
            C_CNT_ONE:  r = c1;
            C_LASTW:    r = lw;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        if (array_open)
        begin
            entry_pc = (command == CMD_ARR_WORD) ? PC_AWD : PC_ERR2;
        end
        else
        begin
            unique case (command)
                CMD_RESET:     entry_pc = PC_RST;
                CMD_WRITE:     entry_pc = PC_WR;
                CMD_FILL:      entry_pc = PC_FILL;
                CMD_ARR_START: entry_pc = PC_AST;
                CMD_ARR_WORD:  entry_pc = PC_ERR1;
                CMD_READ:      entry_pc = PC_RD;
                default:       entry_pc = PC_NONE;
            endcase
        end
    end

    assign ucw      = ucode_rom(pc_reg);
    assign cnt_zero = (cnt_reg == '0);
    assign cnt_one  = (cnt_reg == cnt_t'(1));

    always_comb
    begin
        ctl.kind    = ucw.kind;
        ctl.src     = ucw.src;
        ctl.sel     = ucw.sel;
        ctl.rel     = cond_eval(ucw.rel, cnt_zero, cnt_one, lastw_reg);
        ctl.last    = cond_eval(ucw.last, cnt_zero, cnt_one, lastw_reg);
        ctl.rval_en = ucw.rval_en;
        ctl.status  = ucw.status;
        ctl.arr_set = ucw.arr_set;
        ctl.arr_clr = ucw.arr_clr & lastw_reg;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        lastw_next = lastw_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            pc_next    = entry_pc;
            cnt_next   = (fill_count > cnt_t'(MAX_FILL)) ? cnt_t'(MAX_FILL) : fill_count;
            lastw_next = last_word;
        end
        else if (step)
        begin
            if (ctl.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = ucw.jmp ? ucw.target : pc_reg + pc_t'(1);
            end
            if (ucw.cnt_dec)
            begin
                cnt_next = cnt_reg - cnt_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pc_reg    <= PC_RST;
            cnt_reg   <= '0;
            lastw_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            lastw_reg <= lastw_next;
        end
    end

    assign busy = busy_reg;

endmodule

// File: rtl/parallel_lcd_bus_master.sv
`timescale 1ns / 1ps
// Top level of the 8080-style parallel panel bus master.
// Depends on plcd_pkg and plcd_seq.
//
// Takes one command beat and emits one output beat per panel bus strobe,
// tlast on the final strobe of the command. A command is accepted when the
// sequencer is idle; the microcode program then emits one strobe per cycle,
// while the output side accepts beats, into a single output register. A
// command makes 1 strobe for errors, 2 for an array word or array start, 4
// for write and read, 5 for reset, 2 + 2 * count for fill (count capped at
// 16). Array state carries across commands; reset of rst_n closes any open
// array.
module parallel_lcd_bus_master
    import plcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] register_index, [23:8] data_word, [28:24] fill_count,
    // [36:29] panel_high_byte, [44:37] panel_low_byte, [47:45] zero
    input  logic [47:0] s_axis_tdata,
    // [2:0] command
    input  logic [2:0]  s_axis_tuser,
    // last_word
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] bus_byte, [8] select_level, [9] release_chip_select,
    // [25:10] read_value, [27:26] status, [31:28] zero
    output logic [31:0] m_axis_tdata,
    // [2:0] beat_kind
    output logic [2:0]  m_axis_tuser,
    // last
    output logic        m_axis_tlast
);

    logic       busy, start, step;
    beat_ctl_t  ctl;

    logic [7:0]  reg_index_reg;
    logic [15:0] word_reg;
    logic [7:0]  panel_hi_reg, panel_lo_reg;
    logic        array_open_reg, array_open_next;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic        sel_reg, rel_reg, last_reg;
    logic [15:0] rval_reg;
    logic [1:0]  status_reg;
    logic [7:0]  beat_byte;

    assign s_axis_tready = !busy;
    assign start = s_axis_tvalid && !busy;
    assign step  = busy && (!m_valid_reg || m_axis_tready);

    plcd_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (s_axis_tuser),
        .array_open (array_open_reg),
        .fill_count (s_axis_tdata[28:24]),
        .last_word  (s_axis_tlast),
        .step       (step),
        .busy       (busy),
        .ctl        (ctl)
    );

    always_comb
    begin
        unique case (ctl.src)
            SRC_ZERO:     beat_byte = 8'h00;
            SRC_REG:      beat_byte = reg_index_reg;
            SRC_WORD_HI:  beat_byte = word_reg[15:8];
            SRC_WORD_LO:  beat_byte = word_reg[7:0];
            SRC_PANEL_HI: beat_byte = panel_hi_reg;
            SRC_PANEL_LO: beat_byte = panel_lo_reg;
            default:      beat_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        array_open_next = array_open_reg;
        if (step && ctl.arr_set)
        begin
            array_open_next = 1'b1;
        end
        else if (step && ctl.arr_clr)
        begin
            array_open_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (step)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_open_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            array_open_reg <= array_open_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            reg_index_reg <= s_axis_tdata[7:0];
            word_reg      <= s_axis_tdata[23:8];
            panel_hi_reg  <= s_axis_tdata[36:29];
            panel_lo_reg  <= s_axis_tdata[44:37];
        end
    end

    // output beat register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            kind_reg   <= ctl.kind;
            byte_reg   <= beat_byte;
            sel_reg    <= ctl.sel;
            rel_reg    <= ctl.rel;
            last_reg   <= ctl.last;
            rval_reg   <= ctl.rval_en ? {panel_hi_reg, panel_lo_reg} : 16'h0000;
            status_reg <= ctl.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'h0, status_reg, rval_reg, rel_reg, sel_reg, byte_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

endmodule
